[design/fpsl_pkg.sv]
// shared constants, types and reset tables of the five-point sensor linearizer
// no dependencies; every other design file imports this package
package fpsl_pkg;

	localparam int DEF_POINT_COUNT = 5;
	localparam int DEF_SAMPLE_BITS = 10;
	localparam int LEVEL_BITS      = 8;
	localparam int DATA_BITS       = 64;
	localparam int LEVEL_SLOTS     = 8;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_EXACT    = 2'd0,
		ST_INTERP   = 2'd1,
		ST_CLAMP_LO = 2'd2,
		ST_CLAMP_HI = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SCAN,
		FS_DONE
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_MUL,
		BS_DIV,
		BS_OUT
	} back_state_t;

	// status, y1, y2, x0, x1, x2
	function automatic int job_bits(input int sample_bits);
		return 2 + 2 * LEVEL_BITS + 3 * sample_bits;
	endfunction

	function automatic int addr_bits(input int points);
		return $clog2(8 * (points + 1));
	endfunction

	function automatic int level_regs(input int points);
		return (points < LEVEL_SLOTS) ? points : LEVEL_SLOTS;
	endfunction

	function automatic logic [15:0] reset_sample(input int idx);
		logic [15:0] val;
		case (idx)
			1:       val = 16'd1023;
			2:       val = 16'd256;
			3:       val = 16'd512;
			4:       val = 16'd768;
			default: val = 16'd0;
		endcase
		return val;
	endfunction

	function automatic logic [LEVEL_BITS-1:0] reset_level(input int idx);
		logic [LEVEL_BITS-1:0] val;
		case (idx)
			1:       val = 8'd255;
			2:       val = 8'd235;
			3:       val = 8'd70;
			4:       val = 8'd50;
			default: val = 8'd0;
		endcase
		return val;
	endfunction

endpackage

[design/five_point_sensor_linearizer.sv]
// a request is scanned against every calibration point and its job queued; an interpolated
// job then passes the slope multiply and the divider loop (eight quotient bits, one a cycle)
// before the result register, while an exact or clamped one goes to the result register directly;
// the front end can take the next request while the back end still works on the last
// reset: arst_n clears the pipeline and queue at once and loads the default
// calibration points; there is no clearing pass
module five_point_sensor_linearizer #(
	parameter int POINT_COUNT = fpsl_pkg::DEF_POINT_COUNT,
	parameter int SAMPLE_BITS = fpsl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	// request side
	input  logic                                        push,
	output logic                                        full,
	input  logic [SAMPLE_BITS-1:0]                      raw_sample,
	// result side
	output logic                                        empty,
	input  logic                                        pop,
	output logic [fpsl_pkg::LEVEL_BITS-1:0]             level,
	output logic [1:0]                                  status,
	// configuration port
	input  logic                                        psel,
	input  logic                                        penable,
	input  logic                                        pwrite,
	input  logic [fpsl_pkg::addr_bits(POINT_COUNT)-1:0] paddr,
	input  logic [fpsl_pkg::DATA_BITS-1:0]              pwdata,
	output logic [fpsl_pkg::DATA_BITS-1:0]              prdata,
	output logic                                        pready
);
	import fpsl_pkg::*;

	localparam int JOB_W = job_bits(SAMPLE_BITS);

	logic [POINT_COUNT-1:0][SAMPLE_BITS-1:0] pt_smp;
	logic [POINT_COUNT-1:0][LEVEL_BITS-1:0]  pt_lvl;
	logic                                    q_push, q_full, q_pop, q_empty;
	logic [JOB_W-1:0]                        q_wdata, q_rdata;

	// no wait states on the configuration port
	assign pready = 1'b1;

	// point samples and levels; the user must write them between requests only, the block does not enforce it
	fpsl_cfg #(
		.POINT_COUNT (POINT_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pt_smp  (pt_smp),
		.pt_lvl  (pt_lvl)
	);

	// front end: exact match, nearest neighbours and span ends in one pass
	fpsl_front #(
		.POINT_COUNT (POINT_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.raw_sample (raw_sample),
		.pt_smp     (pt_smp),
		.pt_lvl     (pt_lvl),
		.q_push     (q_push),
		.q_full     (q_full),
		.q_wdata    (q_wdata)
	);

	// decouples the scan from the divider so either can stall alone
	fpsl_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back end: interpolation and the result register
	fpsl_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_rdata (q_rdata),
		.empty   (empty),
		.pop     (pop),
		.level   (level),
		.status  (status)
	);

endmodule

[design/fpsl_cfg.sv]
// calibration point registers behind the apb-style configuration port
// depends on fpsl_pkg
module fpsl_cfg #(
	parameter int POINT_COUNT = fpsl_pkg::DEF_POINT_COUNT,
	parameter int SAMPLE_BITS = fpsl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 psel,
	input  logic                                                 penable,
	input  logic                                                 pwrite,
	input  logic [fpsl_pkg::addr_bits(POINT_COUNT)-1:0]          paddr,
	input  logic [fpsl_pkg::DATA_BITS-1:0]                       pwdata,
	output logic [fpsl_pkg::DATA_BITS-1:0]                       prdata,
	output logic [POINT_COUNT-1:0][SAMPLE_BITS-1:0]              pt_smp,
	output logic [POINT_COUNT-1:0][fpsl_pkg::LEVEL_BITS-1:0]     pt_lvl
);
	import fpsl_pkg::*;

	localparam int AW    = addr_bits(POINT_COUNT);
	localparam int IW    = AW - 3;
	localparam int PIW   = $clog2(POINT_COUNT);
	localparam int LVL_N = level_regs(POINT_COUNT);

	logic [SAMPLE_BITS-1:0] smp_q [POINT_COUNT];
	logic [LEVEL_BITS-1:0]  lvl_q [LVL_N];
	logic [IW-1:0]          idx;
	logic                   wr_en;
	logic [DATA_BITS-1:0]   lvl_word;

	assign idx   = paddr[AW-1:3];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POINT_COUNT; i++) begin
				smp_q[i] <= SAMPLE_BITS'(reset_sample(i));
			end
			for (int i = 0; i < LVL_N; i++) begin
				lvl_q[i] <= reset_level(i);
			end
		end else if (wr_en) begin
			if (idx < IW'(POINT_COUNT)) begin
				smp_q[idx[PIW-1:0]] <= pwdata[SAMPLE_BITS-1:0];
			end else if (idx == IW'(POINT_COUNT)) begin
				for (int i = 0; i < LVL_N; i++) begin
					lvl_q[i] <= pwdata[LEVEL_BITS*i +: LEVEL_BITS];
				end
			end
		end
	end

	always_comb begin
		lvl_word = '0;
		for (int i = 0; i < LVL_N; i++) begin
			lvl_word[LEVEL_BITS*i +: LEVEL_BITS] = lvl_q[i];
		end
	end

	always_comb begin
		prdata = '0;
		if (idx < IW'(POINT_COUNT)) begin
			prdata = DATA_BITS'(smp_q[idx[PIW-1:0]]);
		end else if (idx == IW'(POINT_COUNT)) begin
			prdata = lvl_word;
		end
	end

	// points past the eighth have no level byte and read as zero
	for (genvar g = 0; g < POINT_COUNT; g++) begin : g_pt
		assign pt_smp[g] = smp_q[g];
		if (g < LVL_N) begin : g_lvl
			assign pt_lvl[g] = lvl_q[g];
		end else begin : g_zero
			assign pt_lvl[g] = '0;
		end
	end

endmodule

[design/fpsl_front.sv]
// front end: takes a request, scans the points one per cycle and classifies it
// depends on fpsl_pkg
module fpsl_front #(
	parameter int POINT_COUNT = fpsl_pkg::DEF_POINT_COUNT,
	parameter int SAMPLE_BITS = fpsl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             push,
	output logic                                             full,
	input  logic [SAMPLE_BITS-1:0]                           raw_sample,
	input  logic [POINT_COUNT-1:0][SAMPLE_BITS-1:0]          pt_smp,
	input  logic [POINT_COUNT-1:0][fpsl_pkg::LEVEL_BITS-1:0] pt_lvl,
	output logic                                             q_push,
	input  logic                                             q_full,
	output logic [fpsl_pkg::job_bits(SAMPLE_BITS)-1:0]       q_wdata
);
	import fpsl_pkg::*;

	localparam int CW = $clog2(POINT_COUNT);

	typedef struct packed {
		status_t                status;
		logic [LEVEL_BITS-1:0]  y1;
		logic [LEVEL_BITS-1:0]  y2;
		logic [SAMPLE_BITS-1:0] x0;
		logic [SAMPLE_BITS-1:0] x1;
		logic [SAMPLE_BITS-1:0] x2;
	} job_t;

	front_state_t state_q, state_d;
	logic         accept;
	logic         last;
	job_t         job;

	logic [SAMPLE_BITS-1:0] smp_sh_q [POINT_COUNT];
	logic [LEVEL_BITS-1:0]  lvl_sh_q [POINT_COUNT];
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] x0_q;
	logic                   match_q, blw_v_q, abv_v_q;
	logic [LEVEL_BITS-1:0]  mlvl_q, blw_l_q, abv_l_q, lo_l_q, hi_l_q;
	logic [SAMPLE_BITS-1:0] blw_s_q, abv_s_q, lo_s_q, hi_s_q;
	logic [SAMPLE_BITS-1:0] s;
	logic [LEVEL_BITS-1:0]  y;

	assign s    = smp_sh_q[0];
	assign y    = lvl_sh_q[0];
	assign last = (cnt_q == CW'(POINT_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		q_push  = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				full = 1'b0;
			end
			FS_SCAN: begin
				if (last) begin
					state_d = FS_DONE;
				end
			end
			FS_DONE: begin
				// hand over and take the next request in the same cycle
				if (!q_full) begin
					q_push  = 1'b1;
					full    = 1'b0;
					state_d = FS_IDLE;
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
		accept = push & ~full;
		if (accept) begin
			state_d = FS_SCAN;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x0_q    <= raw_sample;
			cnt_q   <= '0;
			match_q <= 1'b0;
			blw_v_q <= 1'b0;
			abv_v_q <= 1'b0;
			for (int i = 0; i < POINT_COUNT; i++) begin
				smp_sh_q[i] <= pt_smp[i];
				lvl_sh_q[i] <= pt_lvl[i];
			end
		end else if (state_q == FS_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
			for (int i = 0; i < POINT_COUNT - 1; i++) begin
				smp_sh_q[i] <= smp_sh_q[i+1];
				lvl_sh_q[i] <= lvl_sh_q[i+1];
			end
			// first matching point wins
			if (!match_q && s == x0_q) begin
				match_q <= 1'b1;
				mlvl_q  <= y;
			end
			if (s < x0_q && (!blw_v_q || s > blw_s_q)) begin
				blw_v_q <= 1'b1;
				blw_s_q <= s;
				blw_l_q <= y;
			end
			if (s > x0_q && (!abv_v_q || s < abv_s_q)) begin
				abv_v_q <= 1'b1;
				abv_s_q <= s;
				abv_l_q <= y;
			end
			if (cnt_q == '0 || s < lo_s_q) begin
				lo_s_q <= s;
				lo_l_q <= y;
			end
			if (cnt_q == '0 || s > hi_s_q) begin
				hi_s_q <= s;
				hi_l_q <= y;
			end
		end
	end

	always_comb begin
		job.x0     = x0_q;
		job.x1     = blw_s_q;
		job.x2     = abv_s_q;
		job.y2     = abv_l_q;
		job.status = ST_INTERP;
		job.y1     = blw_l_q;
		if (match_q) begin
			job.status = ST_EXACT;
			job.y1     = mlvl_q;
		end else if (!blw_v_q) begin
			job.status = ST_CLAMP_LO;
			job.y1     = lo_l_q;
		end else if (!abv_v_q) begin
			job.status = ST_CLAMP_HI;
			job.y1     = hi_l_q;
		end
	end

	assign q_wdata = job;

endmodule

[design/fpsl_queue.sv]
// short queue of classified jobs between the front and back ends
// depends on fpsl_pkg
module fpsl_queue #(
	parameter int WIDTH = fpsl_pkg::job_bits(fpsl_pkg::DEF_SAMPLE_BITS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import fpsl_pkg::*;

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]     mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 do_push, do_pop;

	assign full    = (cnt_q == CNTW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[design/fpsl_back.sv]
// back end: slope multiply, eight-step restoring divide, result register
// depends on fpsl_pkg
module fpsl_back #(
	parameter int SAMPLE_BITS = fpsl_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_empty,
	output logic                                       q_pop,
	input  logic [fpsl_pkg::job_bits(SAMPLE_BITS)-1:0] q_rdata,
	output logic                                       empty,
	input  logic                                       pop,
	output logic [fpsl_pkg::LEVEL_BITS-1:0]            level,
	output logic [1:0]                                 status
);
	import fpsl_pkg::*;

	localparam int PW = LEVEL_BITS + SAMPLE_BITS;

	typedef struct packed {
		status_t                status;
		logic [LEVEL_BITS-1:0]  y1;
		logic [LEVEL_BITS-1:0]  y2;
		logic [SAMPLE_BITS-1:0] x0;
		logic [SAMPLE_BITS-1:0] x1;
		logic [SAMPLE_BITS-1:0] x2;
	} job_t;

	back_state_t state_q, state_d;
	job_t        job;
	logic        out_load;

	status_t                st_q;
	logic                   neg_q;
	logic [LEVEL_BITS-1:0]  base_q, dy_q, quo_q;
	logic [SAMPLE_BITS-1:0] dx_q, den_q;
	logic [PW-1:0]          rem_q, dsh_q;
	logic [2:0]             k_q;
	logic                   ovalid_q;
	logic [LEVEL_BITS-1:0]  level_q;
	status_t                status_q;

	assign job    = job_t'(q_rdata);
	assign empty  = ~ovalid_q;
	assign level  = level_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BS_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (job.status == ST_INTERP) ? BS_MUL : BS_OUT;
				end
			end
			BS_MUL: begin
				state_d = BS_DIV;
			end
			BS_DIV: begin
				if (k_q == '0) begin
					state_d = BS_OUT;
				end
			end
			BS_OUT: begin
				if (!ovalid_q || pop) begin
					out_load = 1'b1;
					state_d  = BS_IDLE;
				end
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				if (q_pop) begin
					st_q   <= job.status;
					base_q <= job.y1;
					neg_q  <= (job.status == ST_INTERP) && (job.y2 < job.y1);
					dy_q   <= (job.y2 < job.y1) ? job.y1 - job.y2 : job.y2 - job.y1;
					dx_q   <= job.x0 - job.x1;
					den_q  <= job.x2 - job.x1;
					quo_q  <= '0;
				end
			end
			BS_MUL: begin
				rem_q <= PW'(dy_q) * PW'(dx_q);
				dsh_q <= PW'(den_q) << 7;
				k_q   <= 3'd7;
			end
			BS_DIV: begin
				// quotient stays below 256 since x0 - x1 < x2 - x1
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[LEVEL_BITS-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[LEVEL_BITS-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				k_q   <= k_q - 1'b1;
			end
			BS_OUT: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			level_q  <= neg_q ? base_q - quo_q : base_q + quo_q;
			status_q <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

endmodule

[design/fpsl_check.sv]
// port-level checks on request and result flow of the linearizer
// depends on fpsl_pkg; bound to five_point_sensor_linearizer below
module fpsl_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          pop,
	input logic                          empty,
	input logic [fpsl_pkg::LEVEL_BITS-1:0] level,
	input logic [1:0]                    status
);
	import fpsl_pkg::*;

	// front, two queue slots, back and result register
	localparam logic [2:0] MAX_INFLIGHT = 3'd5;

	logic [2:0] cnt_q;
	logic       inc, dec;

	assign inc = push & ~full;
	assign dec = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (inc && !dec) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (dec && !inc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(level) && $stable(status)))
		else $error("waiting result changed or vanished");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cnt_q != 3'd0))
		else $error("result shown with no request outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_INFLIGHT)
		else $error("more requests in flight than the pipeline holds");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == MAX_INFLIGHT) |-> full)
		else $error("request side open with every stage occupied");

endmodule

bind five_point_sensor_linearizer fpsl_check u_fpsl_check (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.pop    (pop),
	.empty  (empty),
	.level  (level),
	.status (status)
);

[sim/tb_five_point_sensor_linearizer.sv]
// self-checking testbench of five_point_sensor_linearizer: queued requests, random stalls
// on both sides, APB calibration writes between phases; depends on design/fpsl_pkg.sv
// and design/five_point_sensor_linearizer.sv
`timescale 1ns / 1ps

module tb_five_point_sensor_linearizer;

	import fpsl_pkg::*;

	localparam int NPTS        = DEF_POINT_COUNT;
	localparam int SBITS       = DEF_SAMPLE_BITS;
	localparam int ABITS       = addr_bits(NPTS);
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	// register map: one sample register per point, then the packed level register
	localparam int REG_POINT0_SAMPLE = 0;
	localparam int REG_POINT_LEVELS  = NPTS;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] lvl;
		status_t               st;
	} cal_out_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  push       = 1'b0;
	logic                  full;
	logic [SBITS-1:0]      raw_sample = '0;
	logic                  empty;
	logic                  pop        = 1'b0;
	logic [LEVEL_BITS-1:0] level;
	logic [1:0]            status;
	logic                  psel       = 1'b0;
	logic                  penable    = 1'b0;
	logic                  pwrite     = 1'b0;
	logic [ABITS-1:0]      paddr      = '0;
	logic [DATA_BITS-1:0]  pwdata     = '0;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	// calibration as the block should currently hold it
	logic [SBITS-1:0]      cal_sample [NPTS];
	logic [LEVEL_BITS-1:0] cal_level  [NPTS];

	logic [SBITS-1:0] samples_to_send [$];
	cal_out_t         levels_due      [$];
	cal_out_t         oldest_due;

	int n_errors       = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 14;
	int take_stall_pct = 14;

	five_point_sensor_linearizer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.raw_sample (raw_sample),
		.empty      (empty),
		.pop        (pop),
		.level      (level),
		.status     (status),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected level and status for one sample under the current calibration
	function automatic cal_out_t linearize(input logic [SBITS-1:0] x);
		cal_out_t r;
		int below, above, lo, hi;
		int x1, x2, y1, y2, y0;
		below = -1;
		above = -1;
		lo = 0;
		hi = 0;
		// exact hit: lowest-indexed point wins when samples are shared
		for (int i = 0; i < NPTS; i++) begin
			if (cal_sample[i] == x) begin
				r.lvl = cal_level[i];
				r.st  = ST_EXACT;
				return r;
			end
		end
		// nearest neighbours either side, plus the span ends; strict compares
		// keep the lowest index among equal samples
		for (int i = 0; i < NPTS; i++) begin
			if (cal_sample[i] < x && (below < 0 || cal_sample[i] > cal_sample[below]))
				below = i;
			if (cal_sample[i] > x && (above < 0 || cal_sample[i] < cal_sample[above]))
				above = i;
			if (cal_sample[i] < cal_sample[lo])
				lo = i;
			if (cal_sample[i] > cal_sample[hi])
				hi = i;
		end
		if (below < 0) begin
			r.lvl = cal_level[lo];
			r.st  = ST_CLAMP_LO;
		end else if (above < 0) begin
			r.lvl = cal_level[hi];
			r.st  = ST_CLAMP_HI;
		end else begin
			x1 = int'(cal_sample[below]);
			x2 = int'(cal_sample[above]);
			y1 = int'(cal_level[below]);
			y2 = int'(cal_level[above]);
			// signed int division truncates toward zero, as the block must
			y0 = ((y2 - y1) * (int'(x) - x1)) / (x2 - x1) + y1;
			if (y0 < 0)
				y0 = 0;
			if (y0 > 255)
				y0 = 255;
			r.lvl = y0[LEVEL_BITS-1:0];
			r.st  = ST_INTERP;
		end
		return r;
	endfunction

	// request side: feeds the pending queue into the block, predicting each
	// request at the edge that accepts it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push       <= 1'b0;
			raw_sample <= '0;
		end else begin
			if (push && !full)
				levels_due.push_back(linearize(raw_sample));
			// a held request stays put until taken
			if (!push || !full) begin
				if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push       <= 1'b1;
					raw_sample <= samples_to_send.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result side: random back-pressure, every taken result checked in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (levels_due.size() == 0) begin
					n_errors++;
					$display("%0t: result with no request outstanding, level %0d status %0d",
						$time, level, status);
				end else begin
					oldest_due = levels_due.pop_front();
					if (level !== oldest_due.lvl) begin
						n_errors++;
						$display("%0t: level mismatch, expected %0d, got %0d",
							$time, oldest_due.lvl, level);
					end
					if (status !== oldest_due.st) begin
						n_errors++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, oldest_due.st, status);
					end
				end
			end
			pop <= ($urandom_range(99) >= take_stall_pct);
		end
	end

	// watchdog: too long without any handshake on any port means a hang
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((push && !full) || (pop && !empty) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// APB write: setup cycle, then access cycle; the register takes the
	// value at the access edge, so the local copy follows at once
	task automatic write_reg(input int idx, input logic [DATA_BITS-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ABITS'(8 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NPTS)
			cal_sample[idx] = value[SBITS-1:0];
		else if (idx == REG_POINT_LEVELS)
			for (int i = 0; i < NPTS; i++)
				cal_level[i] = value[8*i +: 8];
	endtask

	// wait until every request is in and every result is out
	task automatic drain();
		while (samples_to_send.size() != 0 || push || levels_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// new calibration: spread, clustered, pinned to the range ends, or with
	// shared samples; some registers are left as they were
	task automatic random_calibration();
		logic [DATA_BITS-1:0] value;
		int mode, base;
		mode = $urandom_range(3);
		base = $urandom_range(1023);
		for (int i = 0; i < NPTS; i++) begin
			value = {$urandom, $urandom};
			case (mode)
				0: value[SBITS-1:0] = SBITS'($urandom_range(1023));
				1: value[SBITS-1:0] = SBITS'(base + $urandom_range(40));
				2: begin
					if ($urandom_range(2) == 0)
						value[SBITS-1:0] = SBITS'($urandom_range(1023));
					else
						value[SBITS-1:0] = $urandom_range(1) ? '1 : '0;
				end
				default: value[SBITS-1:0] = SBITS'(base + 100 * $urandom_range(2));
			endcase
			if ($urandom_range(9) < 7)
				write_reg(REG_POINT0_SAMPLE + i, value);
		end
		if ($urandom_range(9) < 8)
			write_reg(REG_POINT_LEVELS, {$urandom, $urandom});
	endtask

	// random samples, biased onto and next to the breakpoints so that exact
	// hits and tight neighbour pairs come up often
	task automatic queue_random_samples(input int n);
		logic [SBITS-1:0] s;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0, 1, 2: s = cal_sample[$urandom_range(NPTS - 1)];
				3, 4:    s = cal_sample[$urandom_range(NPTS - 1)] + SBITS'($urandom_range(2)) - 1'b1;
				5:       s = $urandom_range(1) ? '1 : '0;
				default: s = SBITS'($urandom_range(1023));
			endcase
			samples_to_send.push_back(s);
		end
	endtask

	initial begin
		int sent;
		cal_sample = '{10'd0, 10'd1023, 10'd256, 10'd512, 10'd768};
		cal_level  = '{8'd0, 8'd255, 8'd235, 8'd70, 8'd50};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: exact hits on every point, interpolation in each span
		samples_to_send = '{10'd0, 10'd1023, 10'd256, 10'd512, 10'd768, 10'd1, 10'd255,
			10'd257, 10'd511, 10'd513, 10'd767, 10'd769, 10'd1022};
		drain();

		// unordered points, two sharing a sample, falling slope, junk above
		// the sample bits; every register written
		write_reg(REG_POINT0_SAMPLE + 0, 64'hDEAD_0000_0000_FC64);
		write_reg(REG_POINT0_SAMPLE + 1, 64'd900);
		write_reg(REG_POINT0_SAMPLE + 2, 64'd300);
		write_reg(REG_POINT0_SAMPLE + 3, 64'd300);
		write_reg(REG_POINT0_SAMPLE + 4, 64'd600);
		write_reg(REG_POINT_LEVELS, 64'hA5A5_0080_00FF_C80A);
		samples_to_send = '{10'd50, 10'd100, 10'd300, 10'd301, 10'd599, 10'd601,
			10'd899, 10'd950};
		drain();

		// every point at the bottom of the range: only exact hits and clamp high
		for (int i = 0; i < NPTS; i++)
			write_reg(REG_POINT0_SAMPLE + i, 64'd0);
		write_reg(REG_POINT_LEVELS, 64'h0011_2233_44FF);
		samples_to_send = '{10'd0, 10'd1023};
		drain();

		// every point at the top: only exact hits and clamp low
		for (int i = 0; i < NPTS; i++)
			write_reg(REG_POINT0_SAMPLE + i, 64'd1023);
		write_reg(REG_POINT_LEVELS, 64'h00FF_FFFF_FF00);
		samples_to_send = '{10'd1023, 10'd0};
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			random_calibration();
			// one phase runs flat out on both sides
			send_idle_pct  = (phase == 3) ? 0 : 14;
			take_stall_pct = (phase == 3) ? 0 : 14;
			if (phase == 6) begin
				// short bursts, each left to empty out before the next
				sent = 0;
				while (sent < 100) begin
					queue_random_samples($urandom_range(1, 6));
					sent = sent + samples_to_send.size();
					drain();
				end
			end else begin
				queue_random_samples(100);
				drain();
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[five_point_sensor_linearizer.f]
design/fpsl_pkg.sv
design/fpsl_cfg.sv
design/fpsl_front.sv
design/fpsl_queue.sv
design/fpsl_back.sv
design/five_point_sensor_linearizer.sv
design/fpsl_check.sv
sim/tb_five_point_sensor_linearizer.sv
